// File: hw/rtl/bc1_bc3_block_decoder_unit_defines.svh
// Assertion macros for the block decoder. Each macro expects a clock named clk and an
// active high reset named rst in the module that uses it.
`ifndef BC1_BC3_BLOCK_DECODER_UNIT_DEFINES_SVH
`define BC1_BC3_BLOCK_DECODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCDEC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCDEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bcdec_pkg.sv
package bcdec_pkg;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgb_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgba_t;

  typedef struct packed {
    logic [9:0] b;
    logic [9:0] g;
    logic [9:0] r;
  } rgb_sum_t;

  // Load enables for the three pipeline stages behind the input register.
  typedef struct packed {
    logic en_b;
    logic en_c;
    logic en_d;
  } pipe_ctl_t;

  localparam int unsigned NumTexels = 16;
  localparam int unsigned NumPairs = 8;
  localparam int unsigned NumRampMix = 6;
  localparam logic [7:0] AlphaOpaque = 8'd255;

  // Division by three for values below 768, by reciprocal multiplication.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  // Division by seven for values below 1792.
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd2341;
    return p[21:14];
  endfunction

  // Division by five for values below 1280.
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd1639;
    return p[20:13];
  endfunction

  function automatic rgb_t expand565(input logic [15:0] v);
    rgb_t c;
    c.r = {v[15:11], v[15:13]};
    c.g = {v[10:5], v[10:9]};
    c.b = {v[4:0], v[4:2]};
    return c;
  endfunction

endpackage

// File: hw/rtl/bc1_bc3_block_decoder_unit.sv
// BC1/BC3 block decoder. One compressed 4x4 block goes in as color_block and alpha_block,
// and its sixteen RGBA8 texels come out on texel_pair_0 to texel_pair_7, two texels to a
// port, lower texel in the lower word. The block accepts one item in every cycle while
// in_stall is low, and passes each item through an input register, a stage that
// expands the endpoints and forms the weighted sums, a stage that divides by three, five
// or seven with constant reciprocal multipliers, and the output register that holds the
// selected texels. When out_stall holds a result, the stages behind it keep filling, so
// in_stall rises only once all four stages hold an item. format_bc3 selects BC1 (0) or
// BC3 (1); write it through cfg_write and cfg_data only while no item is in flight.
`include "bc1_bc3_block_decoder_unit_defines.svh"

module bc1_bc3_block_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] color_block,
  input  logic [63:0] alpha_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] texel_pair_0,
  output logic [63:0] texel_pair_1,
  output logic [63:0] texel_pair_2,
  output logic [63:0] texel_pair_3,
  output logic [63:0] texel_pair_4,
  output logic [63:0] texel_pair_5,
  output logic [63:0] texel_pair_6,
  output logic [63:0] texel_pair_7
);

  // Mode register: 0 decodes BC1 blocks, 1 decodes BC3 blocks.
  logic format_bc3;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_bc3 <= 1'b0;
    end else if (cfg_write) begin
      format_bc3 <= cfg_data;
    end
  end

  // Valid bits of the four stages. A stage loads whenever it is empty or the stage after
  // it moves on, so bubbles close up and a stalled output keeps only its own item.
  logic v_a;
  logic v_b;
  logic v_c;
  logic v_d;
  logic ready_a;
  logic ready_b;
  logic ready_c;
  logic ready_d;
  bcdec_pkg::pipe_ctl_t ctl;

  always_comb begin
    ready_d  = !v_d || !out_stall;
    ready_c  = !v_c || ready_d;
    ready_b  = !v_b || ready_c;
    ready_a  = !v_a || ready_b;
    ctl.en_b = ready_b;
    ctl.en_c = ready_c;
    ctl.en_d = ready_d;
  end

  assign in_stall  = !ready_a;
  assign out_valid = v_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else begin
      if (ready_a) begin
        v_a <= in_valid;
      end
      if (ready_b) begin
        v_b <= v_a;
      end
      if (ready_c) begin
        v_c <= v_b;
      end
      if (ready_d) begin
        v_d <= v_c;
      end
    end
  end

  // Input register, then the selector fields travel alongside the palette work.
  logic [63:0] cb_a;
  logic [63:0] ab_a;
  logic [31:0] csel_b;
  logic [47:0] asel_b;
  logic [31:0] csel_c;
  logic [47:0] asel_c;

  always_ff @(posedge clk) begin
    if (ready_a) begin
      cb_a <= color_block;
      ab_a <= alpha_block;
    end
    if (ctl.en_b) begin
      csel_b <= cb_a[63:32];
      asel_b <= ab_a[63:16];
    end
    if (ctl.en_c) begin
      csel_c <= csel_b;
      asel_c <= asel_b;
    end
  end

  bcdec_pkg::rgba_t [3:0] pal;
  logic [7:0]             ramp [8];
  bcdec_pkg::rgba_t [bcdec_pkg::NumTexels-1:0] texels;

  bcdec_color_pal u_color_pal (
    .clk       (clk),
    .ctl       (ctl),
    .endpoints (cb_a[31:0]),
    .pal       (pal)
  );

  bcdec_alpha_ramp u_alpha_ramp (
    .clk       (clk),
    .ctl       (ctl),
    .endpoints (ab_a[15:0]),
    .ramp      (ramp)
  );

  bcdec_texel_sel u_texel_sel (
    .clk        (clk),
    .ctl        (ctl),
    .format_bc3 (format_bc3),
    .pal        (pal),
    .ramp       (ramp),
    .color_sel  (csel_c),
    .alpha_sel  (asel_c),
    .texels     (texels)
  );

  assign texel_pair_0 = {texels[1], texels[0]};
  assign texel_pair_1 = {texels[3], texels[2]};
  assign texel_pair_2 = {texels[5], texels[4]};
  assign texel_pair_3 = {texels[7], texels[6]};
  assign texel_pair_4 = {texels[9], texels[8]};
  assign texel_pair_5 = {texels[11], texels[10]};
  assign texel_pair_6 = {texels[13], texels[12]};
  assign texel_pair_7 = {texels[15], texels[14]};

  // The input side stalls only when every stage holds an item.
  `BCDEC_ASSERT_NOW(a_stall_only_full, in_stall, v_a && v_b && v_c && v_d, "stall with a free stage")
  // An item in the last work stage moves into an empty output register.
  `BCDEC_ASSERT_NEXT(a_no_bubble_hold, v_c && !v_d, v_d, "item did not reach the output")
  // An accepted item occupies the input register in the next cycle.
  `BCDEC_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, v_a, "accepted item was dropped")

endmodule

// File: hw/rtl/bcdec_color_pal.sv
module bcdec_color_pal (
  input  logic                    clk,
  input  bcdec_pkg::pipe_ctl_t    ctl,
  input  logic [31:0]             endpoints,
  output bcdec_pkg::rgba_t [3:0]  pal
);

  bcdec_pkg::rgb_t     c0;
  bcdec_pkg::rgb_t     c1;
  bcdec_pkg::rgb_t     half;
  bcdec_pkg::rgb_sum_t n2;
  bcdec_pkg::rgb_sum_t n3;
  logic                four;

  bcdec_pkg::rgb_t     x0;
  bcdec_pkg::rgb_t     x1;
  logic [8:0]          sr;
  logic [8:0]          sg;
  logic [8:0]          sb;

  always_comb begin
    x0 = bcdec_pkg::expand565(endpoints[15:0]);
    x1 = bcdec_pkg::expand565(endpoints[31:16]);
    sr = 9'(x0.r) + 9'(x1.r);
    sg = 9'(x0.g) + 9'(x1.g);
    sb = 9'(x0.b) + 9'(x1.b);
  end

  // First stage: expanded endpoints and the weighted sums that feed the thirds.
  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      c0     <= x0;
      c1     <= x1;
      four   <= endpoints[15:0] > endpoints[31:16];
      half.r <= sr[8:1];
      half.g <= sg[8:1];
      half.b <= sb[8:1];
      n2.r   <= 10'({x0.r, 1'b0}) + 10'(x1.r);
      n2.g   <= 10'({x0.g, 1'b0}) + 10'(x1.g);
      n2.b   <= 10'({x0.b, 1'b0}) + 10'(x1.b);
      n3.r   <= 10'(x0.r) + 10'({x1.r, 1'b0});
      n3.g   <= 10'(x0.g) + 10'({x1.g, 1'b0});
      n3.b   <= 10'(x0.b) + 10'({x1.b, 1'b0});
    end
  end

  // Second stage: build the four palette entries, dividing by three in four-color mode.
  always_ff @(posedge clk) begin
    if (ctl.en_c) begin
      pal[0] <= {bcdec_pkg::AlphaOpaque, c0};
      pal[1] <= {bcdec_pkg::AlphaOpaque, c1};
      if (four) begin
        pal[2] <= {bcdec_pkg::AlphaOpaque, bcdec_pkg::div3(n2.b),
                   bcdec_pkg::div3(n2.g), bcdec_pkg::div3(n2.r)};
        pal[3] <= {bcdec_pkg::AlphaOpaque, bcdec_pkg::div3(n3.b),
                   bcdec_pkg::div3(n3.g), bcdec_pkg::div3(n3.r)};
      end else begin
        pal[2] <= {bcdec_pkg::AlphaOpaque, half};
        pal[3] <= '0;
      end
    end
  end

endmodule

// File: hw/rtl/bcdec_alpha_ramp.sv
module bcdec_alpha_ramp (
  input  logic                  clk,
  input  bcdec_pkg::pipe_ctl_t  ctl,
  input  logic [15:0]           endpoints,
  output logic [7:0]            ramp [8]
);

  logic [7:0]  a0;
  logic [7:0]  a1;
  logic        seven;
  logic [10:0] num [bcdec_pkg::NumRampMix];
  logic [10:0] num_next [bcdec_pkg::NumRampMix];

  // Numerators of the interpolated steps; the five-step ramp uses only the first four.
  always_comb begin
    for (int i = 0; i < bcdec_pkg::NumRampMix; i++) begin
      if (endpoints[7:0] > endpoints[15:8] || i >= 4) begin
        num_next[i] = 11'(6 - i) * 11'(endpoints[7:0]) + 11'(1 + i) * 11'(endpoints[15:8]);
      end else begin
        num_next[i] = 11'(4 - i) * 11'(endpoints[7:0]) + 11'(1 + i) * 11'(endpoints[15:8]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      a0    <= endpoints[7:0];
      a1    <= endpoints[15:8];
      seven <= endpoints[7:0] > endpoints[15:8];
      num   <= num_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_c) begin
      ramp[0] <= a0;
      ramp[1] <= a1;
      for (int i = 0; i < 4; i++) begin
        ramp[2 + i] <= seven ? bcdec_pkg::div7(num[i]) : bcdec_pkg::div5(num[i]);
      end
      ramp[6] <= seven ? bcdec_pkg::div7(num[4]) : 8'd0;
      ramp[7] <= seven ? bcdec_pkg::div7(num[5]) : bcdec_pkg::AlphaOpaque;
    end
  end

endmodule

// File: hw/rtl/bcdec_texel_sel.sv
module bcdec_texel_sel (
  input  logic                    clk,
  input  bcdec_pkg::pipe_ctl_t    ctl,
  input  logic                    format_bc3,
  input  bcdec_pkg::rgba_t [3:0]  pal,
  input  logic [7:0]              ramp [8],
  input  logic [31:0]             color_sel,
  input  logic [47:0]             alpha_sel,
  output bcdec_pkg::rgba_t [bcdec_pkg::NumTexels-1:0] texels
);

  bcdec_pkg::rgba_t [bcdec_pkg::NumTexels-1:0] texels_next;

  always_comb begin
    for (int t = 0; t < bcdec_pkg::NumTexels; t++) begin
      texels_next[t] = pal[color_sel[2*t +: 2]];
      if (format_bc3) begin
        texels_next[t].a = ramp[alpha_sel[3*t +: 3]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_d) begin
      texels <= texels_next;
    end
  end

endmodule
